/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define U8NG_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`define U8NG_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define U8NG_ASSERT_IMPL(lbl, cond, prop, msg)
`define U8NG_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

/* sv/u8ng_pkg.sv */
// Types and constants of the UTF-8 character n-gram splitter.
package u8ng_pkg;

  localparam int DEF_MAX_GRAM     = 8;
  localparam int DEF_STRING_BYTES = 65536;
  localparam int OFFSET_LIMIT     = 65536;

  typedef enum logic [1:0] {
    ST_GRAM     = 2'd0,
    ST_BAD_UTF8 = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] gram_start;
    logic [16:0] gram_end;
    status_t     status;
    logic        string_done;
  } res_t;

  typedef struct packed {
    logic        done;
    logic        bad;
    logic [15:0] char_start;
  } dec_t;

endpackage

/* sv/u8ng_if.sv */
// Valid/ready channel interfaces for input words, result words and configuration.
interface u8ng_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_string;
  modport source (output valid, output data_byte, output last_of_string, input ready);
  modport sink (input valid, input data_byte, input last_of_string, output ready);
endinterface

interface u8ng_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] gram_start;
  logic [16:0] gram_end;
  logic [1:0]  status;
  logic        string_done;
  modport source (output valid, output gram_start, output gram_end, output status,
                  output string_done, input ready);
  modport sink (input valid, input gram_start, input gram_end, input status,
                input string_done, output ready);
endinterface

interface u8ng_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] gram_chars;
  modport source (output valid, output gram_chars, input ready);
  modport sink (input valid, input gram_chars, output ready);
endinterface

/* sv/u8ng_decoder.sv */
// Strict UTF-8 sequence decoder holding the pending lead byte and count.
module u8ng_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic             clear_en,
  input  logic [7:0]       data_byte,
  input  logic [15:0]      offset,
  output u8ng_pkg::dec_t   dec
);
  import u8ng_pkg::*;

  logic [7:0]  lead_r, lead_nxt;
  logic [1:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] char_start_r;

  always_comb begin
    lead_nxt       = lead_r;
    bytes_left_nxt = bytes_left_r;
    dec.done       = 1'b0;
    dec.bad        = 1'b0;
    dec.char_start = char_start_r;
    if (bytes_left_r == 2'd0) begin
      dec.char_start = offset;
      if (!data_byte[7]) begin
        dec.done = 1'b1;
      end else begin
        lead_nxt = data_byte;
        if ((data_byte & 8'he0) == 8'hc0 && (data_byte & 8'h1e) != 8'h00) begin
          bytes_left_nxt = 2'd1;
        end else if ((data_byte & 8'hf0) == 8'he0) begin
          bytes_left_nxt = 2'd2;
        end else if ((data_byte & 8'hf8) == 8'hf0 && data_byte <= 8'hf4) begin
          bytes_left_nxt = 2'd3;
        end else begin
          dec.bad = 1'b1;
        end
      end
    end else begin
      if ((data_byte & 8'hc0) != 8'h80) begin
        dec.bad = 1'b1;
      end else begin
        // second byte of a three-byte form: reject overlongs and surrogates
        if ((lead_r & 8'hf0) == 8'he0 && bytes_left_r == 2'd2) begin
          if ((lead_r & 8'h0f) == 8'h00 && (data_byte & 8'h20) == 8'h00) dec.bad = 1'b1;
          if (lead_r == 8'hed && (data_byte & 8'h20) != 8'h00) dec.bad = 1'b1;
        // second byte of a four-byte form: reject overlongs and values past U+10FFFF
        end else if ((lead_r & 8'hf8) == 8'hf0 && bytes_left_r == 2'd3) begin
          if ((lead_r & 8'h07) == 8'h00 && (data_byte & 8'h30) == 8'h00) dec.bad = 1'b1;
          if (lead_r == 8'hf4 && data_byte > 8'h8f) dec.bad = 1'b1;
        end
      end
      bytes_left_nxt = bytes_left_r - 2'd1;
      dec.done = !dec.bad && (bytes_left_r == 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 2'd0;
    end else if (clear_en) begin
      bytes_left_r <= 2'd0;
    end else if (step_en) begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      lead_r       <= lead_nxt;
      char_start_r <= dec.char_start;
    end
  end

endmodule

/* sv/u8ng_cell.sv */
// One window cell: holds a code point start offset and passes it down the row.
module u8ng_cell (
  input  logic        clk,
  input  logic        shift_en,
  input  logic [15:0] start_in,
  output logic [15:0] start_q
);
  logic [15:0] start_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      start_r <= start_in;
    end
  end

  assign start_q = start_r;

endmodule

/* sv/u8ng_window.sv */
// Row of cells with the start offsets of the last code points, and the gram tap.
module u8ng_window #(
  parameter int MAX_GRAM = u8ng_pkg::DEF_MAX_GRAM,
  localparam int N_W     = $clog2(MAX_GRAM + 1)
) (
  input  logic           clk,
  input  logic           shift_en,
  input  logic [15:0]    new_start,
  input  logic [N_W-1:0] gram_n,
  output logic [15:0]    gram_start
);
  logic [15:0] q [MAX_GRAM];

  for (genvar i = 0; i < MAX_GRAM; i++) begin : g_cell
    logic [15:0] d;
    if (i == MAX_GRAM - 1) begin : g_head
      assign d = new_start;
    end else begin : g_body
      assign d = q[i+1];
    end
    u8ng_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .start_in (d),
      .start_q  (q[i])
    );
  end

  // pick the entry that will sit gram_n places from the head after this shift
  always_comb begin
    gram_start = new_start;
    for (int i = 1; i < MAX_GRAM; i++) begin
      if (i == MAX_GRAM - int'(gram_n) + 1) gram_start = q[i];
    end
  end

endmodule

/* sv/u8ng_skid.sv */
// Output register with a skid stage so input keeps flowing while results wait.
module u8ng_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u8ng_pkg::res_t  push_data,
  input  logic            out_ready,
  output logic            out_valid,
  output u8ng_pkg::res_t  out_data,
  output logic            can_accept
);
  import u8ng_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_data_r;
  res_t skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) out_data_r <= skid_data_r;
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign can_accept = !skid_valid_r;

endmodule

/* sv/utf8_char_ngram_splitter.sv */
// Top level of the UTF-8 character n-gram splitter.
// Usage:
//   in_ch takes one string byte per word with last_of_string on the final byte.
//   out_ch gives one result word per completed gram, per UTF-8 error (status 1,
//   zero span) or per string that runs past the offset limit (status 2).
//   cfg_ch writes gram_chars (0 acts as 1, values above MAX_GRAM clamp); write
//   it only while no word is in flight.
// A result is registered in the output stage, or in the skid stage while out_ch stalls.
// Throughput: one byte per cycle while in_ch ready is high; decode, window shift
//   and tap selection all take place in the same cycle as the byte's acceptance.
// After a failed string the remaining bytes are taken and give no results.
// Reset clears the decoder, counters and result buffer and sets gram_chars to 3;
//   the window cells are written before they are read in each string.
// When out_ch stalls, a skid stage holds one more result; in_ch ready drops
//   only while both output and skid are full.
module utf8_char_ngram_splitter #(
  parameter int MAX_GRAM     = u8ng_pkg::DEF_MAX_GRAM,
  parameter int STRING_BYTES = u8ng_pkg::DEF_STRING_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  u8ng_in_if.sink     in_ch,
  u8ng_out_if.source  out_ch,
  u8ng_cfg_if.sink    cfg_ch
);
  import u8ng_pkg::*;
  `include "assert_macros.svh"

  localparam int N_W = $clog2(MAX_GRAM + 1);
  localparam int unsigned CAP = (STRING_BYTES > OFFSET_LIMIT) ? OFFSET_LIMIT : STRING_BYTES;

  logic [3:0]     gram_chars_r;
  logic [16:0]    byte_offset_r;
  logic [N_W-1:0] chars_seen_r, chars_seen_nxt;
  logic           string_failed_r;

  logic           accept, last, overflow, step_en, trunc, emit, push, can_accept;
  logic [N_W-1:0] gram_n;
  logic [15:0]    tap_start;
  dec_t           dec;
  res_t           res, out_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gram_chars_r <= 4'd3;
    end else if (cfg_ch.valid) begin
      gram_chars_r <= cfg_ch.gram_chars;
    end
  end

  always_comb begin
    if (gram_chars_r == 4'd0) begin
      gram_n = N_W'(1);
    end else if (int'(gram_chars_r) > MAX_GRAM) begin
      gram_n = N_W'(MAX_GRAM);
    end else begin
      gram_n = N_W'(gram_chars_r);
    end
  end

  assign in_ch.ready = can_accept;
  assign accept   = in_ch.valid && can_accept;
  assign last     = in_ch.last_of_string;
  assign overflow = 32'(byte_offset_r) >= CAP;
  assign step_en  = accept && !string_failed_r && !overflow;
  assign trunc    = last && !dec.done && !dec.bad;

  u8ng_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .clear_en  (accept && last),
    .data_byte (in_ch.data_byte),
    .offset    (byte_offset_r[15:0]),
    .dec       (dec)
  );

  u8ng_window #(.MAX_GRAM(MAX_GRAM)) u_window (
    .clk        (clk),
    .shift_en   (step_en && dec.done),
    .new_start  (dec.char_start),
    .gram_n     (gram_n),
    .gram_start (tap_start)
  );

  assign chars_seen_nxt = (int'(chars_seen_r) < MAX_GRAM) ? chars_seen_r + N_W'(1)
                                                          : chars_seen_r;
  assign emit = dec.done && (chars_seen_nxt >= gram_n);

  always_comb begin
    res.gram_start  = 16'd0;
    res.gram_end    = 17'd0;
    res.status      = ST_GRAM;
    res.string_done = last;
    push            = 1'b0;
    if (accept && !string_failed_r) begin
      if (overflow) begin
        res.status = ST_TOO_LONG;
        push       = 1'b1;
      end else if (dec.bad || trunc) begin
        res.status = ST_BAD_UTF8;
        push       = 1'b1;
      end else if (emit) begin
        res.gram_start = tap_start;
        res.gram_end   = byte_offset_r + 17'd1;
        push           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r   <= 17'd0;
      chars_seen_r    <= '0;
      string_failed_r <= 1'b0;
    end else if (accept) begin
      if (last) begin
        byte_offset_r   <= 17'd0;
        chars_seen_r    <= '0;
        string_failed_r <= 1'b0;
      end else if (!string_failed_r) begin
        if (overflow || dec.bad) begin
          string_failed_r <= 1'b1;
        end else begin
          byte_offset_r <= byte_offset_r + 17'd1;
          if (dec.done) chars_seen_r <= chars_seen_nxt;
        end
      end
    end
  end

  u8ng_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_res),
    .can_accept (can_accept)
  );

  assign out_ch.gram_start  = out_res.gram_start;
  assign out_ch.gram_end    = out_res.gram_end;
  assign out_ch.status      = out_res.status;
  assign out_ch.string_done = out_res.string_done;

  `U8NG_ASSERT_IMPL(a_stall_full, !in_ch.ready, out_ch.valid, "input stalled with empty output")
  `U8NG_ASSERT_IMPL(a_gram_span, out_ch.valid && out_ch.status == ST_GRAM, out_ch.gram_end > {1'b0, out_ch.gram_start}, "empty gram span")
  `U8NG_ASSERT_IMPL(a_err_span, out_ch.valid && out_ch.status != ST_GRAM, out_ch.gram_start == 16'd0 && out_ch.gram_end == 17'd0, "error result with span")
  `U8NG_ASSERT_NEXT(a_str_clear, accept && last, byte_offset_r == 17'd0 && chars_seen_r == '0 && !string_failed_r, "string state not cleared")

endmodule
